// File: rtl/msr_pkg.sv
// ----------------------------------------------------------------------------
// msr_pkg
// Shared types, constants and the angle-to-PWM table of the servo ramp block.
// ----------------------------------------------------------------------------
package msr_pkg;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_MIN_ANGLE       = 2'd0,
		CFG_MAX_ANGLE       = 2'd1,
		CFG_STEP_ANGLE      = 2'd2,
		CFG_UPDATE_INTERVAL = 2'd3
	} cfg_reg_t;

	// Item operation codes.
	localparam logic OP_SET_TARGET = 1'b0;
	localparam logic OP_TICK       = 1'b1;

	localparam int          CFG_DATA_W        = 16;
	localparam logic [7:0]  ANGLE_RESET       = 8'd90;
	localparam logic [7:0]  MIN_ANGLE_RESET   = 8'd0;
	localparam logic [7:0]  MAX_ANGLE_RESET   = 8'd180;
	localparam logic [7:0]  STEP_ANGLE_RESET  = 8'd1;
	localparam logic [15:0] INTERVAL_RESET    = 16'd20;
	localparam logic [15:0] ELAPSED_MAX       = 16'hFFFF;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;       // latch the incoming item
		logic wr_target;  // clamp and store the latched target
		logic first;      // start a scan at channel zero
		logic rd;         // issue a state read for the next channel
		logic commit;     // write back the channel under scan
		logic flush;      // send the held result as the final one
	} msr_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic due;         // channel under scan updates on this tick
		logic pend_valid;  // a result waits in the holding register
		logic out_free;    // the output register can take a result
		logic last_ch;     // channel under scan is the highest one
	} msr_stat_t;

	typedef logic [8:0] pwm_table_t [256];

	// Pulse width is 500 us plus angle * 2000 / 180 us, scaled to a 4096 count
	// period of 20 ms. Angles above 180 use the 180 degree value.
	function automatic pwm_table_t build_pwm_table();
		pwm_table_t tab;
		int         ang;
		int         pulse;
		int         cnt;
		for (int a = 0; a < 256; a++) begin
			ang   = (a > 180) ? 180 : a;
			pulse = 500 + (ang * 2000) / 180;
			cnt   = (pulse * 4096) / 20000;
			if (cnt > 511) begin
				cnt = 511;
			end
			tab[a] = 9'(cnt);
		end
		return tab;
	endfunction

	localparam pwm_table_t PWM_TABLE = build_pwm_table();

endpackage

// File: rtl/msr_ram.sv
// ----------------------------------------------------------------------------
// msr_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module msr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic                                 re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/msr_ctrl.sv
// ----------------------------------------------------------------------------
// msr_ctrl
// Sequencer of the servo ramp block: takes items, runs the channel scan of a
// tick and sends the final result of the scan.
// ----------------------------------------------------------------------------
module msr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               op,
	output logic               in_stall,
	output msr_pkg::msr_cmd_t  cmd,
	input  msr_pkg::msr_stat_t st
);

	typedef enum logic [2:0] {
		IDLE_S,
		SET_S,
		PRIME_S,
		CALC_S,
		FLUSH_S
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   commit_ok;

	// A due channel needs room for the result that it pushes out.
	assign commit_ok = !st.due || !st.pend_valid || st.out_free;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			IDLE_S: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = (op == msr_pkg::OP_TICK) ? PRIME_S : SET_S;
				end
			end
			SET_S: begin
				cmd.wr_target = 1'b1;
				state_d       = IDLE_S;
			end
			PRIME_S: begin
				cmd.first = 1'b1;
				cmd.rd    = 1'b1;
				state_d   = CALC_S;
			end
			CALC_S: begin
				if (commit_ok) begin
					cmd.commit = 1'b1;
					if (st.last_ch) begin
						state_d = FLUSH_S;
					end else begin
						cmd.rd = 1'b1;
					end
				end
			end
			FLUSH_S: begin
				if (!st.pend_valid) begin
					state_d = IDLE_S;
				end else if (st.out_free) begin
					cmd.flush = 1'b1;
					state_d   = IDLE_S;
				end
			end
			default: begin
				state_d = IDLE_S;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE_S;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != IDLE_S);

	// A scan pauses partway only for lack of room: commits are refused only then.
	a_commit_when_room: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == CALC_S && commit_ok |-> cmd.commit)
		else $error("scan held although the result had room");

	a_scan_ends_in_flush: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && st.last_ch |=> state_q == FLUSH_S)
		else $error("scan of the last channel did not end in flush");

	a_set_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == SET_S |=> state_q == IDLE_S)
		else $error("target write did not return to idle");

endmodule

// File: rtl/msr_dp.sv
// ----------------------------------------------------------------------------
// msr_dp
// Datapath of the servo ramp block: configuration registers, channel state
// memories, step and PWM logic, result holding and output registers.
// ----------------------------------------------------------------------------
module msr_dp #(
	parameter int CHANNELS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  msr_pkg::msr_cmd_t             cmd,
	output msr_pkg::msr_stat_t            st,
	input  logic [3:0]                    channel,
	input  logic signed [9:0]             angle_request,
	input  logic                          cfg_wr_en,
	input  logic [1:0]                    cfg_index,
	input  logic [msr_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [3:0]                    out_channel,
	output logic [7:0]                    out_angle,
	output logic [8:0]                    pwm_count,
	output logic                          last
);

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// Configuration registers.
	logic [7:0]  min_angle_q;
	logic [7:0]  max_angle_q;
	logic [7:0]  step_angle_q;
	logic [15:0] interval_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_angle_q  <= msr_pkg::MIN_ANGLE_RESET;
			max_angle_q  <= msr_pkg::MAX_ANGLE_RESET;
			step_angle_q <= msr_pkg::STEP_ANGLE_RESET;
			interval_q   <= msr_pkg::INTERVAL_RESET;
		end else if (cfg_wr_en) begin
			case (msr_pkg::cfg_reg_t'(cfg_index))
				msr_pkg::CFG_MIN_ANGLE:       min_angle_q  <= cfg_wdata[7:0];
				msr_pkg::CFG_MAX_ANGLE:       max_angle_q  <= cfg_wdata[7:0];
				msr_pkg::CFG_STEP_ANGLE:      step_angle_q <= cfg_wdata[7:0];
				msr_pkg::CFG_UPDATE_INTERVAL: interval_q   <= cfg_wdata[15:0];
				default: begin
				end
			endcase
		end
	end

	// Latched set-target item.
	logic [3:0]        item_ch_q;
	logic signed [9:0] item_req_q;
	logic              item_ok_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_ch_q  <= channel;
			item_req_q <= angle_request;
			item_ok_q  <= (int'(channel) < CHANNELS);
		end
	end

	// Clamp up to the low limit first, then down to the high limit.
	logic signed [9:0]  req_lo;
	logic [7:0]         tgt_clamped;
	logic [IDX_W+3:0]   item_ch_wide;
	logic [IDX_W-1:0]   tgt_waddr;

	always_comb begin
		req_lo = item_req_q;
		if (req_lo < $signed({2'b00, min_angle_q})) begin
			req_lo = $signed({2'b00, min_angle_q});
		end
		if (req_lo > $signed({2'b00, max_angle_q})) begin
			tgt_clamped = max_angle_q;
		end else begin
			tgt_clamped = req_lo[7:0];
		end
	end

	assign item_ch_wide = {{IDX_W{1'b0}}, item_ch_q};
	assign tgt_waddr    = item_ch_wide[IDX_W-1:0];

	// Scan index and read address.
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] rd_addr;

	assign rd_addr = cmd.first ? '0 : IDX_W'(idx_q + 1'b1);

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			idx_q <= rd_addr;
		end
	end

	// Valid bits stand for the reset value of entries never written.
	logic [CHANNELS-1:0] state_vld_q;
	logic [CHANNELS-1:0] tgt_vld_q;
	logic                tgt_we;

	assign tgt_we = cmd.wr_target && item_ok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_vld_q <= '0;
			tgt_vld_q   <= '0;
		end else begin
			if (cmd.commit) begin
				state_vld_q[idx_q] <= 1'b1;
			end
			if (tgt_we) begin
				tgt_vld_q[tgt_waddr] <= 1'b1;
			end
		end
	end

	// Channel state: current angle in the upper byte, elapsed ticks below.
	logic [23:0] state_rdata;
	logic [23:0] state_wdata;
	logic [7:0]  tgt_rdata;

	msr_ram #(
		.WIDTH (24),
		.DEPTH (CHANNELS)
	) u_state_ram (
		.clk   (clk),
		.we    (cmd.commit),
		.waddr (idx_q),
		.wdata (state_wdata),
		.re    (cmd.rd),
		.raddr (rd_addr),
		.rdata (state_rdata)
	);

	msr_ram #(
		.WIDTH (8),
		.DEPTH (CHANNELS)
	) u_tgt_ram (
		.clk   (clk),
		.we    (tgt_we),
		.waddr (tgt_waddr),
		.wdata (tgt_clamped),
		.re    (cmd.rd),
		.raddr (rd_addr),
		.rdata (tgt_rdata)
	);

	// Step of the channel under scan.
	logic [7:0]  cur_rd;
	logic [7:0]  tgt_rd;
	logic [15:0] ela_rd;
	logic [15:0] ela_inc;
	logic        due;
	logic [7:0]  new_cur;

	assign cur_rd  = state_vld_q[idx_q] ? state_rdata[23:16] : msr_pkg::ANGLE_RESET;
	assign ela_rd  = state_vld_q[idx_q] ? state_rdata[15:0] : 16'd0;
	assign tgt_rd  = tgt_vld_q[idx_q] ? tgt_rdata : msr_pkg::ANGLE_RESET;
	assign ela_inc = (ela_rd == msr_pkg::ELAPSED_MAX) ? ela_rd : ela_rd + 16'd1;
	assign due     = (ela_inc >= interval_q);

	always_comb begin
		if (!due) begin
			new_cur = cur_rd;
		end else if (cur_rd < tgt_rd) begin
			new_cur = (step_angle_q >= 8'(tgt_rd - cur_rd)) ? tgt_rd
				: 8'(cur_rd + step_angle_q);
		end else if (cur_rd > tgt_rd) begin
			new_cur = (step_angle_q >= 8'(cur_rd - tgt_rd)) ? tgt_rd
				: 8'(cur_rd - step_angle_q);
		end else begin
			new_cur = cur_rd;
		end
	end

	assign state_wdata = {new_cur, due ? 16'd0 : ela_inc};

	// Results: one held back until the next due channel or the scan end
	// shows whether it is the last of the tick.
	logic             pend_valid_q;
	logic [IDX_W-1:0] pend_idx_q;
	logic [7:0]       pend_angle_q;
	logic [8:0]       pend_pwm_q;
	logic             out_valid_q;
	logic [IDX_W-1:0] out_idx_q;
	logic [7:0]       out_angle_q;
	logic [8:0]       out_pwm_q;
	logic             out_last_q;
	logic             out_free;
	logic             push_pend;
	logic             move_out;

	assign out_free  = !out_valid_q || !out_stall;
	assign push_pend = cmd.commit && due;
	assign move_out  = (push_pend && pend_valid_q) || cmd.flush;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (push_pend) begin
				pend_valid_q <= 1'b1;
			end else if (cmd.flush) begin
				pend_valid_q <= 1'b0;
			end
			if (move_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_pend) begin
			pend_idx_q   <= idx_q;
			pend_angle_q <= new_cur;
			pend_pwm_q   <= msr_pkg::PWM_TABLE[new_cur];
		end
		if (move_out) begin
			out_idx_q   <= pend_idx_q;
			out_angle_q <= pend_angle_q;
			out_pwm_q   <= pend_pwm_q;
			out_last_q  <= cmd.flush;
		end
	end

	logic [IDX_W+3:0] out_idx_wide;

	assign out_idx_wide = {4'b0000, out_idx_q};
	assign out_valid    = out_valid_q;
	assign out_channel  = out_idx_wide[3:0];
	assign out_angle    = out_angle_q;
	assign pwm_count    = out_pwm_q;
	assign last         = out_last_q;

	assign st.due        = due;
	assign st.pend_valid = pend_valid_q;
	assign st.out_free   = out_free;
	assign st.last_ch    = (int'(idx_q) == CHANNELS - 1);

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		move_out |-> out_free)
		else $error("result moved over a stalled output item");

	a_step_up_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && cur_rd < tgt_rd |-> new_cur >= cur_rd && new_cur <= tgt_rd)
		else $error("upward step left the range toward the target");

	a_step_down_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && cur_rd > tgt_rd |-> new_cur <= cur_rd && new_cur >= tgt_rd)
		else $error("downward step left the range toward the target");

endmodule

// File: rtl/multi_servo_slew_ramp.sv
// ----------------------------------------------------------------------------
// multi_servo_slew_ramp
// Multi-channel servo ramp controller with PWM count results.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): an item with op 0 sets the target angle
// of one channel, clamped to min_angle and then max_angle; it gives no result.
// An item with op 1 is a one millisecond tick: every channel counts it, and
// each channel whose count reaches update_interval steps its angle toward its
// target and gives one result, in ascending channel order, the final one
// marked by last.
// A tick primes a read of the state memory's registered read port, then scans
// one channel a cycle through that port while the receiver does not stall,
// and then sends the final result.
// One item is worked on at a time; in_stall is high until it is done.
// Output channel (out_valid/out_stall): results sit in an output register;
// a stall holds it and pauses the scan only when a further result is ready.
// Configuration (cfg_wr_en, cfg_index, cfg_wdata) is to be written only while idle; the block does not enforce this.
// Reset sets every channel's angle and target to 90 degrees, clears the tick
// counts and loads the register reset values; no clearing pass is needed.
// ----------------------------------------------------------------------------
module multi_servo_slew_ramp #(
	parameter int CHANNELS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          op,
	input  logic [3:0]                    channel,
	input  logic signed [9:0]             angle_request,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [3:0]                    out_channel,
	output logic [7:0]                    out_angle,
	output logic [8:0]                    pwm_count,
	output logic                          last,
	input  logic                          cfg_wr_en,
	input  logic [1:0]                    cfg_index,
	input  logic [msr_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	msr_pkg::msr_cmd_t  cmd;
	msr_pkg::msr_stat_t st;

	msr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.op       (op),
		.in_stall (in_stall),
		.cmd      (cmd),
		.st       (st)
	);

	msr_dp #(
		.CHANNELS (CHANNELS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.channel       (channel),
		.angle_request (angle_request),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_channel   (out_channel),
		.out_angle     (out_angle),
		.pwm_count     (pwm_count),
		.last          (last)
	);

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multi-channel servo ramp controller.
// ----------------------------------------------------------------------------
// A directed script covers limit clamping, the angle and count extremes, a
// zero step, a zero and a maximum update interval and a low limit above the
// high one. Random items follow under several register settings and three
// mixes of sender and receiver idling, with one long receiver hold.
// Every accepted item runs through a local copy of the servo state, and each
// result written by the block is compared with the oldest predicted write.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int SERVOS         = 16;
	localparam int SETTLE_CYCLES  = 40;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int PHASE_ITEMS    = 44;
	localparam int SCRIPT_ROWS    = 18;

	typedef struct packed {
		logic [3:0] ch;
		logic [7:0] ang;
		logic [8:0] pwm;
		logic       fin;
	} servo_write_t;

	// One row of the directed script. A row may load new register values
	// before its item, and a tick row may carry a hand-computed write.
	typedef struct packed {
		logic              new_cfg;
		logic [7:0]        lo;
		logic [7:0]        hi;
		logic [7:0]        stp;
		logic [15:0]       ivl;
		logic              opc;
		logic [3:0]        ch;
		logic signed [9:0] req;
		logic              probe;
		logic [3:0]        p_ch;
		logic [7:0]        p_ang;
		logic [8:0]        p_pwm;
	} ramp_row_t;

	logic                           clk;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_stall;
	logic                           op;
	logic [3:0]                     channel;
	logic signed [9:0]              angle_request;
	logic                           out_valid;
	logic                           out_stall;
	logic [3:0]                     out_channel;
	logic [7:0]                     out_angle;
	logic [8:0]                     pwm_count;
	logic                           last;
	logic                           cfg_wr_en;
	logic [1:0]                     cfg_index;
	logic [msr_pkg::CFG_DATA_W-1:0] cfg_wdata;

	// Local copy of the servo state and registers.
	logic [7:0]  angle_now [SERVOS];
	logic [7:0]  angle_goal [SERVOS];
	logic [15:0] elapsed [SERVOS];
	int          min_r;
	int          max_r;
	int          step_r;
	int          interval_r;

	// What the latest tick wrote, per channel.
	logic        tick_due [SERVOS];
	logic [7:0]  tick_ang [SERVOS];
	logic [8:0]  tick_pwm [SERVOS];

	servo_write_t servo_writes_q [$];
	servo_write_t want;
	ramp_row_t    script [SCRIPT_ROWS];

	logic signed [9:0] corner_req [8];

	int   errors;
	int   quiet_cycles;
	int   tx_idle_pct;
	int   rx_idle_pct;
	int   hold_left;
	logic hold_go;
	logic hold_taken;

	multi_servo_slew_ramp #(.CHANNELS(SERVOS)) DUT (.*);

	always #5 clk = ~clk;

	function automatic logic [8:0] pulse_count(input int deg);
		int a;
		int us;
		int cnt;
		a   = (deg > 180) ? 180 : deg;
		us  = 500 + (a * 2000) / 180;
		cnt = (us * 4096) / 20000;
		if (cnt > 511) begin
			cnt = 511;
		end
		return cnt[8:0];
	endfunction

	task automatic clamp_target(input logic [3:0] c, input logic signed [9:0] r);
		int req;
		req = int'(r);
		if (req < min_r) begin
			req = min_r;
		end
		if (req > max_r) begin
			req = max_r;
		end
		angle_goal[c] = req[7:0];
	endtask

	// One tick: every channel counts, and due channels step toward their
	// target and are written in ascending order.
	task automatic advance_servos();
		servo_write_t batch [SERVOS];
		int           e;
		int           cur;
		int           tgt;
		int           final_ch;
		final_ch = -1;
		for (int i = 0; i < SERVOS; i++) begin
			e = int'(elapsed[i]);
			if (e < 65535) begin
				e++;
			end
			elapsed[i]  = e[15:0];
			tick_due[i] = 1'b0;
			if (e >= interval_r) begin
				cur = int'(angle_now[i]);
				tgt = int'(angle_goal[i]);
				if (cur < tgt) begin
					cur += step_r;
					if (cur > tgt) begin
						cur = tgt;
					end
				end else if (cur > tgt) begin
					cur -= step_r;
					if (cur < tgt) begin
						cur = tgt;
					end
				end
				angle_now[i]  = cur[7:0];
				elapsed[i]    = 16'd0;
				tick_due[i]   = 1'b1;
				tick_ang[i]   = cur[7:0];
				tick_pwm[i]   = pulse_count(cur);
				batch[i].ch   = i[3:0];
				batch[i].ang  = cur[7:0];
				batch[i].pwm  = tick_pwm[i];
				batch[i].fin  = 1'b0;
				final_ch      = i;
			end
		end
		for (int i = 0; i < SERVOS; i++) begin
			if (tick_due[i]) begin
				batch[i].fin = (i == final_ch);
				servo_writes_q.push_back(batch[i]);
			end
		end
	endtask

	// Called just after a rising edge; returns at the edge that accepts the item.
	task automatic send_item(input logic o, input logic [3:0] c,
			input logic signed [9:0] r);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		op            <= o;
		channel       <= c;
		angle_request <= r;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		if (o == msr_pkg::OP_TICK) begin
			advance_servos();
		end else begin
			clamp_target(c, r);
		end
	endtask

	task automatic write_reg(input msr_pkg::cfg_reg_t idx,
			input logic [msr_pkg::CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			msr_pkg::CFG_MIN_ANGLE:       min_r      = int'(data[7:0]);
			msr_pkg::CFG_MAX_ANGLE:       max_r      = int'(data[7:0]);
			msr_pkg::CFG_STEP_ANGLE:      step_r     = int'(data[7:0]);
			msr_pkg::CFG_UPDATE_INTERVAL: interval_r = int'(data);
			default: ;
		endcase
	endtask

	// Waits for the block to go idle, then loads all four registers. The upper
	// byte of the 8-bit registers carries random bits that must be ignored.
	task automatic set_config(input logic [7:0] lo, input logic [7:0] hi,
			input logic [7:0] stp, input logic [15:0] ivl);
		logic [7:0] junk;
		in_valid <= 1'b0;
		while (servo_writes_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		junk = 8'($urandom_range(255));
		write_reg(msr_pkg::CFG_MIN_ANGLE, {junk, lo});
		junk = 8'($urandom_range(255));
		write_reg(msr_pkg::CFG_MAX_ANGLE, {junk, hi});
		junk = 8'($urandom_range(255));
		write_reg(msr_pkg::CFG_STEP_ANGLE, {junk, stp});
		write_reg(msr_pkg::CFG_UPDATE_INTERVAL, ivl);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic pick_setup(input int mix, input int ph);
		logic [7:0]  lo;
		logic [7:0]  hi;
		logic [7:0]  stp;
		logic [15:0] ivl;
		lo  = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
			: 8'($urandom_range(90));
		hi  = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
			: 8'($urandom_range(91, 180));
		stp = ($urandom_range(4) == 0) ? 8'($urandom_range(255))
			: 8'($urandom_range(1, 20));
		ivl = ($urandom_range(9) == 0) ? 16'($urandom_range(65535))
			: 16'($urandom_range(3));
		if (ph == 1) begin
			case (mix)
				0: begin lo = 8'd0;   hi = 8'd180; stp = 8'd180; ivl = 16'd0; end
				1: begin lo = 8'd180; hi = 8'd0;   stp = 8'd255; ivl = 16'd1; end
				default: begin lo = 8'd255; hi = 8'd255; stp = 8'd0; ivl = 16'hFFFF; end
			endcase
		end else if (mix == 2 && ph == 0) begin
			// Every tick writes all channels while the receiver holds off.
			ivl = 16'd0;
		end
		set_config(lo, hi, stp, ivl);
	endtask

	task automatic random_item();
		logic              o;
		logic [3:0]        c;
		logic signed [9:0] r;
		int                kind;
		o    = ($urandom_range(99) < 55) ? msr_pkg::OP_TICK : msr_pkg::OP_SET_TARGET;
		c    = 4'($urandom_range(15));
		kind = int'($urandom_range(9));
		if (kind < 6) begin
			r = 10'($urandom_range(180));
		end else if (kind < 8) begin
			r = 10'($urandom_range(1023));
		end else begin
			r = corner_req[3'($urandom_range(7))];
		end
		send_item(o, c, r);
	endtask

	// Receiver: random stalls, and one long hold when asked for.
	always @(posedge clk) begin
		if (hold_go && !hold_taken) begin
			hold_taken = 1'b1;
			hold_left  = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	// Result checking and the watchdog.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (out_valid && !out_stall) begin
			if (servo_writes_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected write ch %0d angle %0d count %0d last %0b",
					$time, out_channel, out_angle, pwm_count, last);
			end else begin
				want = servo_writes_q.pop_front();
				if ({out_channel, out_angle, pwm_count, last} !== want) begin
					errors++;
					$display("%0t: expected ch %0d angle %0d count %0d last %0b",
						$time, want.ch, want.ang, want.pwm, want.fin);
					$display("%0t:   actual ch %0d angle %0d count %0d last %0b",
						$time, out_channel, out_angle, pwm_count, last);
				end
			end
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
			$display("FAIL multi_servo_slew_ramp");
			$finish;
		end
	end

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		op            = msr_pkg::OP_SET_TARGET;
		channel       = 4'd0;
		angle_request = 10'd0;
		out_stall     = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_index     = msr_pkg::CFG_MIN_ANGLE;
		cfg_wdata     = '0;
		errors        = 0;
		quiet_cycles  = 0;
		tx_idle_pct   = 0;
		rx_idle_pct   = 0;
		hold_left     = 0;
		hold_go       = 1'b0;
		hold_taken    = 1'b0;
		min_r         = int'(msr_pkg::MIN_ANGLE_RESET);
		max_r         = int'(msr_pkg::MAX_ANGLE_RESET);
		step_r        = int'(msr_pkg::STEP_ANGLE_RESET);
		interval_r    = int'(msr_pkg::INTERVAL_RESET);
		for (int i = 0; i < SERVOS; i++) begin
			angle_now[i]  = msr_pkg::ANGLE_RESET;
			angle_goal[i] = msr_pkg::ANGLE_RESET;
			elapsed[i]    = 16'd0;
			tick_due[i]   = 1'b0;
			tick_ang[i]   = 8'd0;
			tick_pwm[i]   = 9'd0;
		end
		// 10'h200 is -512, 10'h3FF is -1 and 10'h1FF is 511.
		corner_req = '{10'h200, 10'h3FF, 10'd0, 10'd256, 10'd180, 10'd181,
			10'd255, 10'h1FF};
		script = '{
			'{1'b1, 8'd0, 8'd180, 8'd180, 16'd0, msr_pkg::OP_SET_TARGET, 4'd0,
				10'h200, 1'b0, 4'd0, 8'd0, 9'd0},
			'{1'b0, 8'd0, 8'd0, 8'd0, 16'd0, msr_pkg::OP_SET_TARGET, 4'd1,
				10'h1FF, 1'b0, 4'd0, 8'd0, 9'd0},
			'{1'b0, 8'd0, 8'd0, 8'd0, 16'd0, msr_pkg::OP_SET_TARGET, 4'd15,
				10'd0, 1'b0, 4'd0, 8'd0, 9'd0},
			'{1'b0, 8'd0, 8'd0, 8'd0, 16'd0, msr_pkg::OP_TICK, 4'd0,
				10'd0, 1'b1, 4'd0, 8'd0, 9'd102},
			'{1'b0, 8'd0, 8'd0, 8'd0, 16'd0, msr_pkg::OP_TICK, 4'd0,
				10'd0, 1'b1, 4'd1, 8'd180, 9'd511},
			'{1'b0, 8'd0, 8'd0, 8'd0, 16'd0, msr_pkg::OP_TICK, 4'd0,
				10'd0, 1'b1, 4'd3, 8'd90, 9'd307},
			'{1'b1, 8'd200, 8'd100, 8'd0, 16'd1, msr_pkg::OP_SET_TARGET, 4'd4,
				10'd0, 1'b0, 4'd0, 8'd0, 9'd0},
			'{1'b0, 8'd0, 8'd0, 8'd0, 16'd0, msr_pkg::OP_TICK, 4'd0,
				10'd0, 1'b1, 4'd4, 8'd90, 9'd307},
			'{1'b0, 8'd0, 8'd0, 8'd0, 16'd0, msr_pkg::OP_SET_TARGET, 4'd8,
				10'd150, 1'b0, 4'd0, 8'd0, 9'd0},
			'{1'b1, 8'd0, 8'd255, 8'd180, 16'd2, msr_pkg::OP_SET_TARGET, 4'd5,
				10'd255, 1'b0, 4'd0, 8'd0, 9'd0},
			'{1'b0, 8'd0, 8'd0, 8'd0, 16'd0, msr_pkg::OP_SET_TARGET, 4'd6,
				10'h1FF, 1'b0, 4'd0, 8'd0, 9'd0},
			'{1'b0, 8'd0, 8'd0, 8'd0, 16'd0, msr_pkg::OP_SET_TARGET, 4'd7,
				10'h3FF, 1'b0, 4'd0, 8'd0, 9'd0},
			'{1'b0, 8'd0, 8'd0, 8'd0, 16'd0, msr_pkg::OP_TICK, 4'd0,
				10'd0, 1'b0, 4'd0, 8'd0, 9'd0},
			'{1'b0, 8'd0, 8'd0, 8'd0, 16'd0, msr_pkg::OP_TICK, 4'd0,
				10'd0, 1'b1, 4'd5, 8'd255, 9'd511},
			'{1'b0, 8'd0, 8'd0, 8'd0, 16'd0, msr_pkg::OP_TICK, 4'd0,
				10'd0, 1'b0, 4'd0, 8'd0, 9'd0},
			'{1'b1, 8'd0, 8'd180, 8'd1, 16'hFFFF, msr_pkg::OP_SET_TARGET, 4'd9,
				10'd45, 1'b0, 4'd0, 8'd0, 9'd0},
			'{1'b0, 8'd0, 8'd0, 8'd0, 16'd0, msr_pkg::OP_TICK, 4'd0,
				10'd0, 1'b0, 4'd0, 8'd0, 9'd0},
			'{1'b0, 8'd0, 8'd0, 8'd0, 16'd0, msr_pkg::OP_TICK, 4'd0,
				10'd0, 1'b0, 4'd0, 8'd0, 9'd0}
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < SCRIPT_ROWS; k++) begin
			if (script[k].new_cfg) begin
				set_config(script[k].lo, script[k].hi, script[k].stp, script[k].ivl);
			end
			send_item(script[k].opc, script[k].ch, script[k].req);
			if (script[k].probe && (!tick_due[script[k].p_ch] ||
					tick_ang[script[k].p_ch] !== script[k].p_ang ||
					tick_pwm[script[k].p_ch] !== script[k].p_pwm)) begin
				errors++;
				$display("%0t: row %0d ch %0d expected angle %0d count %0d",
					$time, k, script[k].p_ch, script[k].p_ang, script[k].p_pwm);
				$display("%0t:   predicted due %0b angle %0d count %0d", $time,
					tick_due[script[k].p_ch], tick_ang[script[k].p_ch],
					tick_pwm[script[k].p_ch]);
			end
		end

		// Idling mixes: sender light and receiver heavy, then the reverse, then
		// none. The last mix starts with the long receiver hold.
		for (int mix = 0; mix < 3; mix++) begin
			tx_idle_pct  = (mix == 0) ? 21 : (mix == 1) ? 53 : 0;
			rx_idle_pct <= (mix == 0) ? 53 : (mix == 1) ? 21 : 0;
			for (int ph = 0; ph < 3; ph++) begin
				pick_setup(mix, ph);
				if (mix == 2 && ph == 0) begin
					hold_go <= 1'b1;
				end
				repeat (PHASE_ITEMS) random_item();
			end
		end

		in_valid <= 1'b0;
		while (servo_writes_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("PASS multi_servo_slew_ramp");
		end else begin
			$display("FAIL multi_servo_slew_ramp");
		end
		$finish;
	end

endmodule
